// ===== hdl/awp_pkg.sv =====
// Package: widths, payload structs and latency for the arrowhead wing point block.
package awp_pkg;

  localparam int COORD_WIDTH        = 16;
  localparam int SIZE_FRACTION_BITS = 4;
  localparam int SIZE_WIDTH         = 8 + SIZE_FRACTION_BITS;
  // sine/cosine magnitude, Q1.14, up to 16384
  localparam int TRIG_BITS          = 15;
  localparam int ROOT_STEPS         = 15;
  localparam int FRAC_ALL           = SIZE_FRACTION_BITS + 15;
  localparam int DIFF_WIDTH         = COORD_WIDTH + 1;
  localparam int SQ_WIDTH           = 2 * DIFF_WIDTH;
  localparam int ROOT_WIDTH         = 2 * COORD_WIDTH + 34;
  localparam int LATENCY            = 22;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] tail_x;
    logic signed [COORD_WIDTH-1:0] tail_y;
    logic signed [COORD_WIDTH-1:0] tip_x;
    logic signed [COORD_WIDTH-1:0] tip_y;
    logic [SIZE_WIDTH-1:0]         head_width;
    logic [SIZE_WIDTH-1:0]         head_height;
  } awp_req_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] wing_one_x;
    logic signed [COORD_WIDTH-1:0] wing_one_y;
    logic signed [COORD_WIDTH-1:0] wing_two_x;
    logic signed [COORD_WIDTH-1:0] wing_two_y;
    logic                          zero_length;
  } awp_rsp_t;

endpackage

// ===== hdl/awp_root.sv =====
// Pipelined bit search for one unit-vector component, one result bit per stage.
module awp_root (
  input  logic                                clk,
  input  logic [awp_pkg::SQ_WIDTH-1:0]        sq_self,
  input  logic [awp_pkg::SQ_WIDTH-1:0]        sq_other,
  input  logic                                neg_in,
  output logic [awp_pkg::TRIG_BITS-1:0]       q,
  output logic                                neg
);

  localparam int N  = awp_pkg::ROOT_STEPS;
  localparam int WW = awp_pkg::ROOT_WIDTH;

  // y = len2*(2q-1)^2, p = len2*q; r = sq_self * 2^30
  logic [WW-1:0]                   y    [N+1];
  logic [WW-1:0]                   p    [N+1];
  logic [WW-1:0]                   len2 [N+1];
  logic [WW-1:0]                   r    [N+1];
  logic [awp_pkg::TRIG_BITS-1:0]   qv   [N+1];
  logic                            full [N+1];
  logic                            sgn  [N+1];

  always_ff @(posedge clk) begin
    len2[0] <= WW'(sq_self) + WW'(sq_other);
    y[0]    <= WW'(sq_self) + WW'(sq_other);
    r[0]    <= WW'(sq_self) << 30;
    p[0]    <= '0;
    qv[0]   <= '0;
    full[0] <= 1'b0;
    sgn[0]  <= neg_in;
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    localparam int K = N - 1 - i;
    logic [WW-1:0] cand;
    logic [WW-1:0] trial;
    logic          take;

    // len2*(2t-1)^2 - len2*(2q-1)^2 = 4b * len2*(2q-1+b), with t = q + b
    assign cand  = (((p[i] << 1) - len2[i]) + (len2[i] << K)) << (K + 2);
    assign trial = y[i] + cand;
    assign take  = !full[i] && (trial <= r[i]);

    always_ff @(posedge clk) begin
      len2[i+1] <= len2[i];
      r[i+1]    <= r[i];
      sgn[i+1]  <= sgn[i];
      y[i+1]    <= take ? trial : y[i];
      p[i+1]    <= take ? p[i] + (len2[i] << K) : p[i];
      qv[i+1]   <= take ? (qv[i] | (awp_pkg::TRIG_BITS'(1) << K)) : qv[i];
      // q reached one: no further bit may be added
      full[i+1] <= full[i] | (take && (K == N - 1));
    end
  end

  assign q   = qv[N];
  assign neg = sgn[N];

endmodule

// ===== hdl/arrowhead_wing_points.sv =====
// Top level: arrowhead wing points from line endpoints and head size.
//
// Usage: drive req and pulse start; a request is taken at every rising edge
// where start is high and busy is low. busy is always low, so a new request
// may enter every cycle and many are in flight at once.
// Each result appears on rsp with done high for exactly one cycle, after its
// request has passed all the register stages below, in request order.
// Throughput is one request per cycle. Latency is 22 register stages: the
// 15-stage bit search that forms sine and cosine (one result bit per stage),
// plus difference, square, search load, sign, product, sum and rounding stages.
// The receiver cannot stall; results are never held.
// Reset (synchronous, active high) clears all valid bits; requests in flight
// are dropped and no done pulse follows from them.
// When tail equals tip, both wings equal the tip and zero_length is set.
module arrowhead_wing_points (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  awp_pkg::awp_req_t req,
  output logic              done,
  output awp_pkg::awp_rsp_t rsp
);

  localparam int CW  = awp_pkg::COORD_WIDTH;
  localparam int SW  = awp_pkg::SIZE_WIDTH;
  localparam int F   = awp_pkg::FRAC_ALL;
  localparam int DW  = awp_pkg::DIFF_WIDTH;
  localparam int QW  = awp_pkg::SQ_WIDTH;
  localparam int TW  = awp_pkg::TRIG_BITS + 1;
  localparam int PW  = SW + 1 + TW;
  localparam int VW  = CW + F + 3;
  localparam int RW  = VW - F;
  localparam int LAT = awp_pkg::LATENCY;

  typedef struct packed {
    logic signed [CW-1:0] tip_x;
    logic signed [CW-1:0] tip_y;
    logic [SW-1:0]        w;
    logic [SW-1:0]        h;
    logic                 zero;
  } side_t;

  logic  vld  [LAT];
  side_t side [LAT];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) vld[i] <= 1'b0;
    end else begin
      vld[0] <= start && !busy;
      for (int i = 1; i < LAT; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    side[0] <= '{tip_x: req.tip_x, tip_y: req.tip_y, w: req.head_width,
                 h: req.head_height, zero: (req.tip_x == req.tail_x) &&
                 (req.tip_y == req.tail_y)};
    for (int i = 1; i < LAT; i++) side[i] <= side[i-1];
  end

  // stage 0: differences, y flipped for screen axes
  logic signed [DW-1:0] dx_next, dy_next;
  logic [DW-1:0]        ax, ay;
  logic                 sx, sy;

  assign dx_next = DW'(req.tip_x) - DW'(req.tail_x);
  assign dy_next = DW'(req.tail_y) - DW'(req.tip_y);

  always_ff @(posedge clk) begin
    ax <= dx_next[DW-1] ? DW'(-dx_next) : DW'(dx_next);
    ay <= dy_next[DW-1] ? DW'(-dy_next) : DW'(dy_next);
    sx <= dx_next[DW-1];
    sy <= dy_next[DW-1];
  end

  // stage 1: squares
  logic [QW-1:0] sqx, sqy;
  logic          sx1, sy1;

  always_ff @(posedge clk) begin
    sqx <= QW'(ax) * QW'(ax);
    sqy <= QW'(ay) * QW'(ay);
    sx1 <= sx;
    sy1 <= sy;
  end

  logic [awp_pkg::TRIG_BITS-1:0] qs, qc;
  logic                          ns, nc;

  awp_root u_sin (
    .clk      (clk),
    .sq_self  (sqy),
    .sq_other (sqx),
    .neg_in   (sy1),
    .q        (qs),
    .neg      (ns)
  );

  awp_root u_cos (
    .clk      (clk),
    .sq_self  (sqx),
    .sq_other (sqy),
    .neg_in   (sx1),
    .q        (qc),
    .neg      (nc)
  );

  // sign applied
  logic signed [TW-1:0] s, c;

  always_ff @(posedge clk) begin
    s <= ns ? -$signed({1'b0, qs}) : $signed({1'b0, qs});
    c <= nc ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
  end

  // products
  logic signed [PW-1:0] hc, hs, ws, wc;

  always_ff @(posedge clk) begin
    hc <= PW'($signed({1'b0, side[18].h}) * c);
    hs <= PW'($signed({1'b0, side[18].h}) * s);
    ws <= PW'($signed({1'b0, side[18].w}) * s);
    wc <= PW'($signed({1'b0, side[18].w}) * c);
  end

  // sums, one half added for rounding
  logic signed [VW-1:0] px_w, py_w, hc_w, hs_w, ws_w, wc_w, half_w;
  logic signed [VW-1:0] v1x, v1y, v2x, v2y;

  assign px_w   = {{(VW-CW-F){side[19].tip_x[CW-1]}}, side[19].tip_x, {F{1'b0}}};
  assign py_w   = {{(VW-CW-F){side[19].tip_y[CW-1]}}, side[19].tip_y, {F{1'b0}}};
  assign hc_w   = {{(VW-PW){hc[PW-1]}}, hc};
  assign hs_w   = {{(VW-PW){hs[PW-1]}}, hs};
  assign ws_w   = {{(VW-PW){ws[PW-1]}}, ws};
  assign wc_w   = {{(VW-PW){wc[PW-1]}}, wc};
  assign half_w = VW'(1) << (F - 1);

  always_ff @(posedge clk) begin
    v1x <= px_w - (hc_w <<< 1) + half_w - ws_w;
    v1y <= py_w + (hs_w <<< 1) + half_w - wc_w;
    v2x <= px_w - (hc_w <<< 1) + half_w + ws_w;
    v2y <= py_w + (hs_w <<< 1) + half_w + wc_w;
  end

  // truncate toward zero, then saturate
  function automatic logic signed [CW-1:0] finish(input logic signed [VW-1:0] v);
    logic [VW-1:0]        adj;
    logic signed [RW-1:0] rw;
    adj = v + {{(VW-F){1'b0}}, {F{v[VW-1]}}};
    rw  = adj[VW-1:F];
    if (rw[RW-1:CW-1] == '0 || rw[RW-1:CW-1] == '1) finish = rw[CW-1:0];
    else if (rw[RW-1]) finish = {1'b1, {(CW-1){1'b0}}};
    else finish = {1'b0, {(CW-1){1'b1}}};
  endfunction

  always_ff @(posedge clk) begin
    rsp.zero_length <= side[20].zero;
    if (side[20].zero) begin
      rsp.wing_one_x <= side[20].tip_x;
      rsp.wing_one_y <= side[20].tip_y;
      rsp.wing_two_x <= side[20].tip_x;
      rsp.wing_two_y <= side[20].tip_y;
    end else begin
      rsp.wing_one_x <= finish(v1x);
      rsp.wing_one_y <= finish(v1y);
      rsp.wing_two_x <= finish(v2x);
      rsp.wing_two_y <= finish(v2y);
    end
  end

  assign done = vld[LAT-1];

endmodule

// ===== hdl/awp_checker.sv =====
// Port-level checker for the arrowhead wing point block, with its bind.
module awp_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input awp_pkg::awp_rsp_t rsp
);

  localparam int LAT = awp_pkg::LATENCY;

  logic [$clog2(LAT+1)-1:0] since_rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      since_rst <= '0;
    end else if (since_rst != ($clog2(LAT+1))'(LAT)) begin
      since_rst <= since_rst + 1'b1;
    end
  end

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_latency: assert property (@(posedge clk) disable iff (rst)
      since_rst == ($clog2(LAT+1))'(LAT) |-> done == $past(start && !busy, LAT))
    else $error("done does not follow request by fixed latency");

  a_no_done_after_reset: assert property (@(posedge clk) $fell(rst) |-> !done)
    else $error("done right after reset");

  a_zero_wings: assert property (@(posedge clk) disable iff (rst)
      done && rsp.zero_length |->
      rsp.wing_one_x == rsp.wing_two_x && rsp.wing_one_y == rsp.wing_two_y)
    else $error("zero length wings differ");

endmodule

bind arrowhead_wing_points awp_checker u_awp_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);
